// ===== rtl/core/cksb_pkg.sv =====
package cksb_pkg;

    localparam int MAX_RESOLUTION = 2048;

    // Field widths
    localparam int COORD_W = 11;
    localparam int SIZE_W  = 12;
    localparam int RES_W   = 12;
    localparam int BPP_W   = 3;
    localparam int COLOR_W = 24;
    localparam int OFFS_W  = 24;
    localparam int CNT_W   = $clog2(MAX_RESOLUTION);
    localparam int ORG_W   = RES_W;
    localparam int POS_W   = ORG_W + 1;

    // Stream and configuration port widths
    localparam int S_FIELDS_W = 2 * COORD_W + 2 * SIZE_W + COLOR_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = OFFS_W + COLOR_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_RES     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_Y_RES     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_BPP       = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_KEY = CFG_IDX_W'(3);

    // Register reset values
    localparam logic [RES_W-1:0]   X_RES_RST     = RES_W'(1024);
    localparam logic [RES_W-1:0]   Y_RES_RST     = RES_W'(768);
    localparam logic [BPP_W-1:0]   BPP_RST       = BPP_W'(3);
    localparam logic [COLOR_W-1:0] COLOR_KEY_RST = 24'h00B140;

    typedef logic [SIZE_W-1:0] size_t;
    typedef logic [ORG_W-1:0]  org_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               wr_en;
        logic               last;
    } pix_t;

    // Zero counts as one, oversize saturates at the maximum resolution.
    function automatic size_t clamp_size(input logic [SIZE_W-1:0] v);
        size_t r;
        r = v;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if ({1'b0, v} > (SIZE_W + 1)'(MAX_RESOLUTION)) begin
            r = SIZE_W'(MAX_RESOLUTION);
        end
        return r;
    endfunction

    // Pull the origin back so the sprite ends at the screen edge, floor at zero.
    function automatic org_t fit_origin(input logic [COORD_W-1:0] pos,
                                        input size_t size,
                                        input logic [RES_W-1:0] res);
        logic [POS_W-1:0] ext_sum;
        org_t r;
        ext_sum = POS_W'(pos) + POS_W'(size);
        r = ORG_W'(pos);
        if (ext_sum > POS_W'(res)) begin
            r = (res > RES_W'(size)) ? ORG_W'(res - RES_W'(size)) : '0;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/color_keyed_sprite_blit.sv =====
// Channel  Direction  Ports                              Contents
// s_       in         s_tvalid s_tready s_tdata s_tuser  one source pixel of a sprite
// m_       out        m_tvalid m_tready m_tdata m_tuser  back-buffer write for that pixel
//                     m_tlast                            (tlast on the final pixel)
// cfg_     in         cfg_valid cfg_ready cfg_index      register writes, always ready
//                     cfg_data
//
// One pixel per cycle while m_tready is high; a pixel passes registered stages from
// the input to its result on m_ (accept/counters, row * width + column, times
// bytes per pixel). Each stage holds while the one after it is full and stalled,
// so empty stages keep taking pixels while a result waits. aresetn is synchronous,
// active low, and restores the register defaults and the reset sprite geometry.
module color_keyed_sprite_blit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // dest_x[10:0], dest_y[21:11], sprite_width[33:22], sprite_height[45:34],
    // source_color[69:46], zero fill above
    input  logic [cksb_pkg::S_TDATA_W-1:0]     s_tdata,
    // first_pixel[0]
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // byte_offset[23:0], write_color[47:24]
    output logic [cksb_pkg::M_TDATA_W-1:0]     m_tdata,
    // write_enable[0]
    output logic                               m_tuser,
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cksb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cksb_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cksb_pkg::*;

    // Configuration registers
    logic [RES_W-1:0]   x_res_reg;
    logic [RES_W-1:0]   y_res_reg;
    logic [BPP_W-1:0]   bpp_reg;
    logic [COLOR_W-1:0] color_key_reg;

    // Sprite geometry and raster counters
    org_t             origin_x_reg, origin_x_next;
    org_t             origin_y_reg, origin_y_next;
    logic [CNT_W-1:0] column_count_reg, column_count_next;
    logic [CNT_W-1:0] row_count_reg, row_count_next;
    size_t            held_width_reg, held_width_next;
    size_t            held_height_reg, held_height_next;

    // Input fields
    logic [COORD_W-1:0] in_dest_x, in_dest_y;
    logic [SIZE_W-1:0]  in_width, in_height;
    logic [COLOR_W-1:0] in_color;

    logic             s_accept;
    size_t            w_clamp, h_clamp;
    logic [CNT_W-1:0] cnt_x_eff, cnt_y_eff;
    logic [SIZE_W-1:0] col_inc, row_inc;
    logic             col_wrap, row_wrap;
    logic [POS_W-1:0] col_pos, row_pos;
    pix_t             pix_in;

    // Pipeline stages
    logic               st1_valid_reg, st2_valid_reg, st3_valid_reg;
    logic [POS_W-1:0]   st1_col_reg, st1_row_reg;
    pix_t               st1_pix_reg, st2_pix_reg, st3_pix_reg;
    logic [OFFS_W-1:0]  st2_lin_reg, st3_offs_reg;
    logic [OFFS_W-1:0]  lin_next, offs_next;
    logic               st1_en, st2_en, st3_en;

    assign in_dest_x = s_tdata[COORD_W-1:0];
    assign in_dest_y = s_tdata[2*COORD_W-1:COORD_W];
    assign in_width  = s_tdata[2*COORD_W+SIZE_W-1:2*COORD_W];
    assign in_height = s_tdata[2*COORD_W+2*SIZE_W-1:2*COORD_W+SIZE_W];
    assign in_color  = s_tdata[S_FIELDS_W-1:2*COORD_W+2*SIZE_W];

    assign st3_en   = !st3_valid_reg || m_tready;
    assign st2_en   = !st2_valid_reg || st3_en;
    assign st1_en   = !st1_valid_reg || st2_en;
    assign s_tready = st1_en;
    assign s_accept = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_res_reg     <= X_RES_RST;
            y_res_reg     <= Y_RES_RST;
            bpp_reg       <= BPP_RST;
            color_key_reg <= COLOR_KEY_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_X_RES:     x_res_reg     <= cfg_data[RES_W-1:0];
                REG_Y_RES:     y_res_reg     <= cfg_data[RES_W-1:0];
                REG_BPP:       bpp_reg       <= cfg_data[BPP_W-1:0];
                REG_COLOR_KEY: color_key_reg <= cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // A first pixel restarts the sprite with freshly fitted geometry.
    always_comb begin
        w_clamp = clamp_size(in_width);
        h_clamp = clamp_size(in_height);
        if (s_tuser) begin
            held_width_next  = w_clamp;
            held_height_next = h_clamp;
            origin_x_next    = fit_origin(in_dest_x, w_clamp, x_res_reg);
            origin_y_next    = fit_origin(in_dest_y, h_clamp, y_res_reg);
            cnt_x_eff        = '0;
            cnt_y_eff        = '0;
        end else begin
            held_width_next  = held_width_reg;
            held_height_next = held_height_reg;
            origin_x_next    = origin_x_reg;
            origin_y_next    = origin_y_reg;
            cnt_x_eff        = column_count_reg;
            cnt_y_eff        = row_count_reg;
        end

        col_pos  = POS_W'(origin_x_next) + POS_W'(cnt_x_eff);
        row_pos  = POS_W'(origin_y_next) + POS_W'(cnt_y_eff);
        col_inc  = SIZE_W'(cnt_x_eff) + SIZE_W'(1);
        row_inc  = SIZE_W'(cnt_y_eff) + SIZE_W'(1);
        col_wrap = (col_inc == held_width_next);
        row_wrap = (row_inc == held_height_next);

        // Advance the raster, wrapping back to the sprite's first pixel.
        column_count_next = col_wrap ? '0 : col_inc[CNT_W-1:0];
        if (col_wrap) begin
            row_count_next = row_wrap ? '0 : row_inc[CNT_W-1:0];
        end else begin
            row_count_next = cnt_y_eff;
        end

        pix_in.color = in_color;
        pix_in.wr_en = (in_color != color_key_reg);
        pix_in.last  = col_wrap && row_wrap;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            held_width_reg   <= SIZE_W'(1);
            held_height_reg  <= SIZE_W'(1);
        end else if (s_accept) begin
            origin_x_reg     <= origin_x_next;
            origin_y_reg     <= origin_y_next;
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            held_width_reg   <= held_width_next;
            held_height_reg  <= held_height_next;
        end
    end

    // Offset wraps at 24 bits, so truncating each step is exact.
    assign lin_next  = OFFS_W'(st1_row_reg) * OFFS_W'(x_res_reg) + OFFS_W'(st1_col_reg);
    assign offs_next = OFFS_W'(st2_lin_reg * bpp_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
        end else begin
            if (st1_en) begin
                st1_valid_reg <= s_accept;
            end
            if (st2_en) begin
                st2_valid_reg <= st1_valid_reg;
            end
            if (st3_en) begin
                st3_valid_reg <= st2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_col_reg <= col_pos;
            st1_row_reg <= row_pos;
            st1_pix_reg <= pix_in;
        end
        if (st2_en && st1_valid_reg) begin
            st2_lin_reg <= lin_next;
            st2_pix_reg <= st1_pix_reg;
        end
        if (st3_en && st2_valid_reg) begin
            st3_offs_reg <= offs_next;
            st3_pix_reg  <= st2_pix_reg;
        end
    end

    assign m_tvalid = st3_valid_reg;
    assign m_tdata  = M_TDATA_W'({st3_pix_reg.color, st3_offs_reg});
    assign m_tuser  = st3_pix_reg.wr_en;
    assign m_tlast  = st3_pix_reg.last;

endmodule

// ===== dv/color_keyed_sprite_blit_tb.sv =====
module color_keyed_sprite_blit_tb;
    import cksb_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 200;
    localparam int NUM_PHASES   = 6;
    localparam int DRAIN_CYCLES = 12;
    localparam int SHOWN_ERRORS = 10;

    typedef struct {
        logic               first;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic [SIZE_W-1:0]  w;
        logic [SIZE_W-1:0]  h;
        logic [COLOR_W-1:0] color;
    } sprite_pixel_t;

    typedef struct {
        logic [OFFS_W-1:0]  offs;
        logic [COLOR_W-1:0] color;
        logic               wen;
        logic               last;
    } pixel_write_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // screen settings as last written
    int               scr_w = int'(X_RES_RST);
    int               scr_h = int'(Y_RES_RST);
    int               bpp   = int'(BPP_RST);
    logic [COLOR_W-1:0] key = COLOR_KEY_RST;

    // sprite walk state
    int org_x   = 0;
    int org_y   = 0;
    int col_cnt = 0;
    int row_cnt = 0;
    int spr_w   = 1;
    int spr_h   = 1;

    sprite_pixel_t sprite_pixels[$];
    pixel_write_t  pending_writes[$];
    sprite_pixel_t cur_pix;
    pixel_write_t  want_write;
    pixel_write_t  seen_write;

    int queued_cnt    = 0;
    int issued_cnt    = 0;
    int accepted_cnt  = 0;
    int err_cnt       = 0;
    int cycle_cnt     = 0;
    int src_idle_pct  = 0;
    int dst_stall_pct = 0;
    bit src_hold      = 1'b0;

    color_keyed_sprite_blit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int limit_size(int v);
        if (v == 0) return 1;
        if (v > MAX_RESOLUTION) return MAX_RESOLUTION;
        return v;
    endfunction

    function automatic int pull_back(int pos, int size, int res);
        if (pos + size > res) return (res > size) ? res - size : 0;
        return pos;
    endfunction

    // Walk the sprite one pixel and return the back-buffer write it causes.
    function automatic pixel_write_t next_pixel_write(sprite_pixel_t px);
        pixel_write_t wr;
        longint offs;
        if (px.first) begin
            spr_w   = limit_size(int'(px.w));
            spr_h   = limit_size(int'(px.h));
            org_x   = pull_back(int'(px.dx), spr_w, scr_w);
            org_y   = pull_back(int'(px.dy), spr_h, scr_h);
            col_cnt = 0;
            row_cnt = 0;
        end
        offs     = (longint'(org_y + row_cnt) * scr_w + (org_x + col_cnt)) * bpp;
        wr.offs  = offs[OFFS_W-1:0];
        wr.color = px.color;
        wr.wen   = (px.color != key);
        wr.last  = (col_cnt + 1 == spr_w) && (row_cnt + 1 == spr_h);
        col_cnt++;
        if (col_cnt >= spr_w) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= spr_h) row_cnt = 0;
        end
        return wr;
    endfunction

    function automatic int pick_origin(int res, int size);
        int v;
        case ($urandom_range(0, 2))
            0: v = int'($urandom_range(0, 2047));
            1: v = int'($urandom_range(0, 7));
            default: v = res - size + int'($urandom_range(0, 4)) - 2;
        endcase
        if (v < 0) v = 0;
        if (v > 2047) v = 2047;
        return v;
    endfunction

    function automatic logic [COLOR_W-1:0] pick_color();
        if ($urandom_range(0, 3) == 0) return key;
        return COLOR_W'($urandom);
    endfunction

    task automatic push_pixel(input logic first, input int dx, input int dy,
                              input int w, input int h, input logic [COLOR_W-1:0] color);
        sprite_pixel_t px;
        px.first = first;
        px.dx    = COORD_W'(dx);
        px.dy    = COORD_W'(dy);
        px.w     = SIZE_W'(w);
        px.h     = SIZE_W'(h);
        px.color = color;
        sprite_pixels.push_back(px);
        queued_cnt++;
    endtask

    // Mostly small complete sprites; some cut short, some run past their end.
    task automatic queue_sprite();
        int w, h, ew, eh, n, pick;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 5);
        end else if (pick < 88) begin
            w = $urandom_range(7, 40);
            h = $urandom_range(1, 2);
        end else begin
            w = $urandom_range(0, 4095);
            h = $urandom_range(0, 4095);
        end
        ew = limit_size(w);
        eh = limit_size(h);
        n  = ew * eh;
        if (n > 64) begin
            n = $urandom_range(1, 24);
        end else begin
            pick = $urandom_range(0, 9);
            if (pick == 0) n = $urandom_range(1, n);
            else if (pick == 1) n = n + int'($urandom_range(1, n));
        end
        push_pixel(1'b1, pick_origin(scr_w, ew), pick_origin(scr_h, eh), w, h, pick_color());
        for (int i = 1; i < n; i++) begin
            push_pixel(1'b0, $urandom_range(0, 2047), $urandom_range(0, 2047),
                       $urandom_range(0, 4095), $urandom_range(0, 4095), pick_color());
        end
    endtask

    task automatic queue_directed();
        // pixels before any sprite header walk the reset geometry
        push_pixel(1'b0, 2047, 2047, 4095, 4095, COLOR_KEY_RST);
        push_pixel(1'b0, 0, 0, 0, 0, 24'hFFFFFF);
        // zero size taken as one, pulled into the bottom right corner
        push_pixel(1'b1, 2047, 2047, 0, 0, 24'h000000);
        // oversize sprite saturates the origin at zero, then restarts mid-sprite
        push_pixel(1'b1, 0, 0, 4095, 4095, COLOR_KEY_RST);
        push_pixel(1'b0, 0, 0, 0, 0, 24'h123456);
        push_pixel(1'b1, 5, 9, 2048, 1, 24'hABCDEF);
        // 3x2 sprite pulled back from both edges, two pixels wrap past its end
        push_pixel(1'b1, 1023, 767, 3, 2, COLOR_KEY_RST);
        push_pixel(1'b0, 0, 0, 0, 0, 24'h00B141);
        push_pixel(1'b0, 2047, 2047, 4095, 4095, 24'h800000);
        push_pixel(1'b0, 0, 0, 0, 0, COLOR_KEY_RST);
        push_pixel(1'b0, 1365, 682, 2730, 1365, 24'h555555);
        push_pixel(1'b0, 682, 1365, 1365, 2730, 24'hAAAAAA);
        push_pixel(1'b0, 0, 0, 0, 0, 24'h000001);
        push_pixel(1'b0, 0, 0, 0, 0, COLOR_KEY_RST);
        push_pixel(1'b1, 0, 0, 1, 1, 24'h00B141);
        // exact fit at the right edge needs no pull back
        push_pixel(1'b1, 1021, 0, 3, 1, 24'h0000FF);
        push_pixel(1'b0, 0, 0, 0, 0, COLOR_KEY_RST);
        push_pixel(1'b0, 0, 0, 0, 0, 24'hFF0000);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_X_RES:     scr_w = int'(val[RES_W-1:0]);
            REG_Y_RES:     scr_h = int'(val[RES_W-1:0]);
            REG_BPP:       bpp   = int'(val[BPP_W-1:0]);
            REG_COLOR_KEY: key   = val[COLOR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int xr, input int yr, input int bp,
                                  input logic [COLOR_W-1:0] ck);
        write_reg(REG_X_RES, CFG_DATA_W'(xr));
        write_reg(REG_Y_RES, CFG_DATA_W'(yr));
        write_reg(REG_BPP, CFG_DATA_W'(bp));
        write_reg(REG_COLOR_KEY, ck);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (accepted_cnt != queued_cnt || pending_writes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic flag_error(input string what, input pixel_write_t want, input pixel_write_t got);
        if (err_cnt < SHOWN_ERRORS) begin
            $display("%0t %s: expected offs %h color %h we %b last %b, got offs %h color %h we %b last %b",
                     $time, what, want.offs, want.color, want.wen, want.last,
                     got.offs, got.color, got.wen, got.last);
        end
        err_cnt++;
    endtask

    // Source side: hold the pixel until its transaction completes.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_writes.push_back(next_pixel_write(cur_pix));
                accepted_cnt++;
            end
            if (!s_tvalid || s_tready) begin
                if (sprite_pixels.size() != 0 && !src_hold &&
                    $urandom_range(0, 99) >= src_idle_pct) begin
                    cur_pix = sprite_pixels.pop_front();
                    issued_cnt++;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_TDATA_W - S_FIELDS_W){1'b0}}, cur_pix.color,
                                 cur_pix.h, cur_pix.w, cur_pix.dy, cur_pix.dx};
                    s_tuser  <= cur_pix.first;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side: compare each write against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen_write.offs  = m_tdata[OFFS_W-1:0];
                seen_write.color = m_tdata[OFFS_W +: COLOR_W];
                seen_write.wen   = m_tuser;
                seen_write.last  = m_tlast;
                if (pending_writes.size() == 0) begin
                    want_write = '{default: '0};
                    flag_error("unexpected write", want_write, seen_write);
                end else begin
                    want_write = pending_writes.pop_front();
                    if (seen_write.offs !== want_write.offs ||
                        seen_write.color !== want_write.color ||
                        seen_write.wen !== want_write.wen ||
                        seen_write.last !== want_write.last) begin
                        flag_error("write mismatch", want_write, seen_write);
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= dst_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int base;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_X_RES;
        cfg_data  = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        queue_directed();
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: apply_settings(2048, 2048, 4, COLOR_W'($urandom));
                1: apply_settings(1, 1, 1, 24'h000000);
                2: apply_settings(640, 480, 0, 24'hFFFFFF);
                3: apply_settings(37, 23, 7, COLOR_W'($urandom));
                4: apply_settings(int'(X_RES_RST), int'(Y_RES_RST), int'(BPP_RST), COLOR_KEY_RST);
                default: apply_settings($urandom_range(1, 2048), $urandom_range(1, 2048),
                                        $urandom_range(0, 7), COLOR_W'($urandom));
            endcase
            case (ph % 4)
                0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
                1: begin src_idle_pct = 87; dst_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  dst_stall_pct = 87; end
                default: begin src_idle_pct = 8; dst_stall_pct = 8; end
            endcase
            base = queued_cnt;
            while (queued_cnt - base < PHASE_ITEMS) queue_sprite();
            if (ph == 0) begin
                // stop feeding mid-stream until every write is out, then resume
                while (sprite_pixels.size() > PHASE_ITEMS / 2) @(posedge aclk);
                src_hold = 1'b1;
                @(posedge aclk);
                while (issued_cnt != accepted_cnt || pending_writes.size() != 0) @(posedge aclk);
                repeat (DRAIN_CYCLES) @(posedge aclk);
                src_hold = 1'b0;
            end
            wait_idle();
        end

        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
